/* hw/rtl/expiring_hash_set_probe_core_defines.svh */
// Assertion macros for the expiring hash set probe core.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef EXPIRING_HASH_SET_PROBE_CORE_DEFINES_SVH
`define EXPIRING_HASH_SET_PROBE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define EHSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ehsp check failed: same-cycle implication");
`define EHSP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ehsp check failed: next-cycle implication");
`else
`define EHSP_ASSERT_IMP(lbl, ante, cons)
`define EHSP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/ehsp_pkg.sv */
// Shared types and constants for the expiring hash set probe core.
// No dependencies; imported by expiring_hash_set_probe_core.
`timescale 1ns / 1ps
`default_nettype none

package ehsp_pkg;

    localparam int INDEX_BITS_DEF = 10;

    localparam int IN_TDATA_W  = 48;   // pid (32) + slot_index (10), padded
    localparam int IN_TUSER_W  = 2;    // operation
    localparam int OUT_TDATA_W = 24;   // found, result_slot, table_full, entry_count
    localparam int SLOT_W      = 10;
    localparam int COUNT_W     = 11;

    localparam logic [31:0] HASH_MULT     = 32'h9E37_79B9;
    localparam logic [2:0]  BACKOFF_CAP   = 3'd6;
    localparam logic [6:0]  LIFE_UNIT     = 7'd1;
    localparam logic [2:0]  BACKOFF_START = 3'd1;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_ADD    = 2'd2;

    typedef struct packed {
        logic [31:0] key;
        logic [7:0]  born;
        logic [7:0]  seen;
        logic [6:0]  life;
        logic [2:0]  backoff;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_ISSUE,
        ST_PROBE,
        ST_ADD_WR,
        ST_DONE
    } ehsp_state_t;

endpackage

`default_nettype wire

/* hw/rtl/expiring_hash_set_probe_core.sv */
// Path: a tick or unused code goes to ST_DONE, an add via ST_ISSUE and ST_ADD_WR,
// a lookup via ST_HASH, ST_ISSUE and ST_PROBE, probing P slots (1 to TABLE_SLOTS)
// one slot per cycle through the single registered read port of the slot memory.
// ST_DONE sets tvalid once the result register is free. Throughput: one transaction
// at a time; the result register lets the next transaction start while a result
// waits. After reset a clearing pass zeroes every slot, s_axis_tready low until it ends.
`timescale 1ns / 1ps
`default_nettype none
`include "expiring_hash_set_probe_core_defines.svh"

module expiring_hash_set_probe_core
    import ehsp_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [31:0] pid, [41:32] slot_index, [47:42] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [0] found, [10:1] result_slot, [11] table_full, [22:12] entry_count, [23] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int TABLE_SLOTS = 1 << INDEX_BITS;
    localparam int IDX_W       = INDEX_BITS;
    localparam int CNT_W       = INDEX_BITS + 1;

    ehsp_state_t state_reg, state_next;

    logic [IDX_W-1:0] clear_idx_reg, clear_idx_next;
    logic [7:0]       now_reg, now_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] probe_cnt_reg, probe_cnt_next;
    logic             have_free_reg, have_free_next;
    logic             out_valid_reg, out_valid_next;

    logic [1:0]             op_reg, op_next;
    logic [31:0]            key_reg, key_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic [31:0]            prod_reg, prod_next;
    logic [IDX_W-1:0]       home_reg, home_next;
    logic [IDX_W-1:0]       s_reg, s_next;
    logic [IDX_W-1:0]       free_reg, free_next;
    logic                   res_found_reg, res_found_next;
    logic [IDX_W-1:0]       res_slot_reg, res_slot_next;
    logic                   res_full_reg, res_full_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    entry_t           slot_mem [TABLE_SLOTS];
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic             accept;
    logic             load_out;
    logic [7:0]       age_born;
    logic [7:0]       age_seen;
    logic             reuse;
    logic [CNT_W-1:0] cnt_inc;
    logic [2:0]       backoff_inc;
    logic [IDX_W-1:0] addr_issue;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load_out      = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Liveness of the entry read back: stale or expired entries may be reused.
    assign age_born    = now_reg - rd_data_reg.born;
    assign age_seen    = now_reg - rd_data_reg.seen;
    assign reuse       = (age_seen > 8'd1) || (age_born >= {1'b0, rd_data_reg.life});
    assign cnt_inc     = probe_cnt_reg + 1'b1;
    assign backoff_inc = (rd_data_reg.backoff < BACKOFF_CAP) ? rd_data_reg.backoff + 3'd1
                                                              : rd_data_reg.backoff;
    assign addr_issue  = (op_reg == OP_ADD) ? pos_reg : prod_reg[31 -: IDX_W];

    always_comb
    begin
        state_next      = state_reg;
        clear_idx_next  = clear_idx_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        probe_cnt_next  = probe_cnt_reg;
        have_free_next  = have_free_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        prod_next       = prod_reg;
        home_next       = home_reg;
        s_next          = s_reg;
        free_next       = free_reg;
        res_found_next  = res_found_reg;
        res_slot_next   = res_slot_reg;
        res_full_next   = res_full_reg;
        out_data_next   = out_data_reg;
        rd_addr         = s_reg;
        wr_en           = 1'b0;
        wr_addr         = s_reg;
        wr_data         = rd_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en          = 1'b1;
                wr_addr        = clear_idx_reg;
                wr_data        = '0;
                clear_idx_next = clear_idx_reg + 1'b1;
                if (clear_idx_reg == IDX_W'(TABLE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next        = s_axis_tuser;
                    key_next       = s_axis_tdata[31:0];
                    pos_next       = IDX_W'(s_axis_tdata[41:32]);
                    res_found_next = 1'b0;
                    res_slot_next  = '0;
                    res_full_next  = 1'b0;
                    case (s_axis_tuser)
                        OP_TICK:
                        begin
                            now_next   = now_reg + 8'd1;
                            state_next = ST_DONE;
                        end
                        OP_LOOKUP: state_next = ST_HASH;
                        OP_ADD:    state_next = ST_ISSUE;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_HASH:
            begin
                prod_next  = key_reg * HASH_MULT;
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                rd_addr        = addr_issue;
                s_next         = addr_issue;
                home_next      = addr_issue;
                probe_cnt_next = '0;
                have_free_next = 1'b0;
                state_next     = (op_reg == OP_ADD) ? ST_ADD_WR : ST_PROBE;
            end
            ST_PROBE:
            begin
                if (rd_data_reg.key == 32'd0)
                begin
                    res_slot_next = have_free_reg ? free_reg : s_reg;
                    state_next    = ST_DONE;
                end
                else if (rd_data_reg.key == key_reg)
                begin
                    if (!reuse)
                    begin
                        res_found_next = 1'b1;
                        wr_en          = 1'b1;
                        wr_data.seen   = now_reg;
                    end
                    res_slot_next = s_reg;
                    state_next    = ST_DONE;
                end
                else
                begin
                    if (reuse && !have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_next      = s_reg;
                    end
                    probe_cnt_next = cnt_inc;
                    if (cnt_inc == CNT_W'(TABLE_SLOTS))
                    begin
                        // Every slot was probed: fall back to a reusable slot or flag full.
                        res_slot_next = have_free_next ? free_next : home_reg;
                        res_full_next = !have_free_next;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        rd_addr = s_reg + 1'b1;
                        s_next  = s_reg + 1'b1;
                    end
                end
            end
            ST_ADD_WR:
            begin
                wr_en         = 1'b1;
                wr_addr       = s_reg;
                res_slot_next = s_reg;
                wr_data.born  = now_reg;
                wr_data.seen  = now_reg;
                if (rd_data_reg.key == key_reg)
                begin
                    wr_data.backoff = backoff_inc;
                    wr_data.life    = LIFE_UNIT << backoff_inc;
                end
                else
                begin
                    wr_data.key     = key_reg;
                    wr_data.life    = LIFE_UNIT;
                    wr_data.backoff = BACKOFF_START;
                    if (count_reg < CNT_W'(TABLE_SLOTS))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, COUNT_W'(count_reg), res_full_reg,
                                      SLOT_W'(res_slot_reg), res_found_reg};
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_idx_reg <= '0;
            now_reg       <= '0;
            count_reg     <= '0;
            probe_cnt_reg <= '0;
            have_free_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_idx_reg <= clear_idx_next;
            now_reg       <= now_next;
            count_reg     <= count_next;
            probe_cnt_reg <= probe_cnt_next;
            have_free_reg <= have_free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        pos_reg       <= pos_next;
        prod_reg      <= prod_next;
        home_reg      <= home_next;
        s_reg         <= s_next;
        free_reg      <= free_next;
        res_found_reg <= res_found_next;
        res_slot_reg  <= res_slot_next;
        res_full_reg  <= res_full_next;
        out_data_reg  <= out_data_next;
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= slot_mem[rd_addr];
    end

    `EHSP_ASSERT_IMP(a_hit_not_full, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[11]))
    `EHSP_ASSERT_IMP(a_probe_bound, state_reg == ST_PROBE, probe_cnt_reg < CNT_W'(TABLE_SLOTS))
    `EHSP_ASSERT_IMP(a_count_sat, s_axis_tready, count_reg <= CNT_W'(TABLE_SLOTS))
    `EHSP_ASSERT_NXT(a_result_loaded, load_out, m_axis_tvalid && (state_reg == ST_IDLE))

endmodule

`default_nettype wire

/* bench/expiring_hash_set_probe_core_tb.sv */
// Testbench for expiring_hash_set_probe_core: directed and random transactions checked
// against a shadow copy of the slot table kept inside the bench.
// Depends on ehsp_pkg and the core RTL only.
`timescale 1ns / 1ps

module expiring_hash_set_probe_core_tb;
    import ehsp_pkg::*;

    localparam int          TABLE_SLOTS  = 1 << SLOT_W;
    localparam logic [1:0]  OP_SPARE     = 2'd3;
    localparam int          IDLE_LIMIT   = 20000;
    localparam int          RANDOM_UNTIL = 900;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          POOL_SIZE    = 24;
    localparam logic [31:0] ABSENT_KEY   = 32'h0BAD_0001;

    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic               full;
        logic [COUNT_W-1:0] count;
    } probe_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Shadow of the slot table and the counters inside the core.
    logic [31:0]        tbl_key     [TABLE_SLOTS];
    logic [7:0]         tbl_born    [TABLE_SLOTS];
    logic [7:0]         tbl_seen    [TABLE_SLOTS];
    logic [6:0]         tbl_life    [TABLE_SLOTS];
    logic [2:0]         tbl_backoff [TABLE_SLOTS];
    logic [7:0]         shadow_now;
    logic [COUNT_W-1:0] shadow_installs;

    probe_result_t pending_results[$];
    logic [31:0]   key_pool [POOL_SIZE];
    int            mismatches;
    int            items_sent;
    int            idle_cycles;
    bit            tx_gaps;
    bit            rx_gaps;
    bit            rx_hold_req;

    expiring_hash_set_probe_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [SLOT_W-1:0] home_of(input logic [31:0] pid);
        logic [31:0] prod;
        prod = pid * HASH_MULT;
        return prod[31 -: SLOT_W];
    endfunction

    // Builds a nonzero key whose hash lands on the given slot by multiplying the
    // wanted product with the inverse of the hash constant.
    function automatic logic [31:0] key_at_home(input logic [SLOT_W-1:0] slot);
        logic [31:0] inv;
        logic [31:0] prod;
        inv = HASH_MULT;
        repeat (5) inv = inv * (32'd2 - HASH_MULT * inv);
        prod = {slot, (22'($urandom) | 22'd1)};
        return prod * inv;
    endfunction

    function automatic probe_result_t shadow_step(input logic [1:0] op,
                                                  input logic [31:0] pid,
                                                  input logic [SLOT_W-1:0] idx);
        probe_result_t     res;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] free_slot;
        bit                have_free;
        bit                done;
        bit                reuse;
        int                n;
        res = '0;
        case (op)
            OP_TICK:
                shadow_now = shadow_now + 8'd1;
            OP_LOOKUP:
            begin
                s = home_of(pid);
                have_free = 1'b0;
                done = 1'b0;
                free_slot = '0;
                if (tbl_key[s] == 32'd0)
                begin
                    res.slot = s;
                    done = 1'b1;
                end
                for (n = 0; !done && n < TABLE_SLOTS; n++)
                begin
                    reuse = (8'(shadow_now - tbl_seen[s]) > 8'd1) ||
                            (8'(shadow_now - tbl_born[s]) >= {1'b0, tbl_life[s]});
                    if (tbl_key[s] == pid)
                    begin
                        if (!reuse)
                        begin
                            tbl_seen[s] = shadow_now;
                            res.found = 1'b1;
                        end
                        res.slot = s;
                        done = 1'b1;
                    end
                    else
                    begin
                        if (reuse && !have_free)
                        begin
                            have_free = 1'b1;
                            free_slot = s;
                        end
                        s = s + 1'b1;
                        if (tbl_key[s] == 32'd0)
                        begin
                            res.slot = have_free ? free_slot : s;
                            done = 1'b1;
                        end
                    end
                end
                // Every slot was probed: reuse a stale or expired one if any was seen.
                if (!done)
                begin
                    res.slot = have_free ? free_slot : s;
                    res.full = !have_free;
                end
            end
            OP_ADD:
            begin
                res.slot = idx;
                if (tbl_key[idx] == pid)
                begin
                    if (tbl_backoff[idx] < BACKOFF_CAP)
                        tbl_backoff[idx] = tbl_backoff[idx] + 3'd1;
                    tbl_life[idx] = LIFE_UNIT << tbl_backoff[idx];
                end
                else
                begin
                    tbl_key[idx] = pid;
                    tbl_life[idx] = LIFE_UNIT;
                    tbl_backoff[idx] = BACKOFF_START;
                    if (shadow_installs < TABLE_SLOTS)
                        shadow_installs = shadow_installs + 1'b1;
                end
                tbl_born[idx] = shadow_now;
                tbl_seen[idx] = shadow_now;
            end
            default:
                ;
        endcase
        res.count = shadow_installs;
        return res;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [31:0] pid,
                             input logic [SLOT_W-1:0] idx, output probe_result_t res);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (!tx_gaps || r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else if (r < 98)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({idx, pid});
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        res = shadow_step(op, pid, idx);
        pending_results.push_back(res);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_corner_cases();
        probe_result_t res;
        logic [31:0]   k_edge;
        logic [31:0]   k_wrap;
        k_edge = key_at_home(SLOT_W'(TABLE_SLOTS - 1));
        k_wrap = key_at_home(SLOT_W'(TABLE_SLOTS - 1));
        send_item(OP_SPARE, '1, '1, res);
        send_item(OP_LOOKUP, '0, '0, res);
        send_item(OP_LOOKUP, '1, '1, res);
        // A zero key added on an empty slot takes the refresh path and installs nothing.
        send_item(OP_ADD, '0, '0, res);
        send_item(OP_LOOKUP, k_edge, '0, res);
        send_item(OP_ADD, k_edge, res.slot, res);
        send_item(OP_LOOKUP, k_edge, '1, res);
        // Same home slot as the last key, so probing wraps from the top slot to slot 0.
        send_item(OP_LOOKUP, k_wrap, '0, res);
        send_item(OP_ADD, k_wrap, res.slot, res);
        send_item(OP_LOOKUP, k_wrap, '0, res);
        send_item(OP_ADD, k_edge, SLOT_W'(TABLE_SLOTS - 1), res);
        send_item(OP_TICK, $urandom, SLOT_W'($urandom), res);
        send_item(OP_LOOKUP, k_edge, '0, res);
        send_item(OP_LOOKUP, k_wrap, '0, res);
        repeat (2) send_item(OP_TICK, '0, '0, res);
        send_item(OP_LOOKUP, k_edge, '0, res);
        send_item(OP_LOOKUP, k_wrap, '0, res);
        send_item(OP_ADD, k_wrap, '0, res);
        send_item(OP_LOOKUP, k_wrap, '1, res);
        send_item(OP_SPARE, '0, '0, res);
        wait_drained();
    endtask

    // An entry added and left alone for a full turn of the tick counter looks fresh again.
    task automatic test_tick_wrap();
        probe_result_t res;
        logic [31:0]   k;
        k = key_at_home(SLOT_W'($urandom));
        send_item(OP_LOOKUP, k, '0, res);
        send_item(OP_ADD, k, res.slot, res);
        repeat (256) send_item(OP_TICK, $urandom, SLOT_W'($urandom), res);
        send_item(OP_LOOKUP, k, '0, res);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        probe_result_t     res;
        logic [31:0]       k;
        logic [SLOT_W-1:0] base;
        int                pick;
        int                i;
        base = SLOT_W'($urandom);
        // Most keys share a narrow band of home slots so that probing has work to do.
        for (i = 0; i < POOL_SIZE; i++)
            key_pool[i] = (i < 20) ? key_at_home(base + SLOT_W'(i % 12)) : $urandom;
        while (items_sent < RANDOM_UNTIL)
        begin
            pick = $urandom_range(0, 99);
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (pick < 45)
            begin
                send_item(OP_LOOKUP, k, SLOT_W'($urandom), res);
                if (!res.found && !res.full && $urandom_range(0, 9) < 8)
                    send_item(OP_ADD, k, res.slot, res);
                repeat ($urandom_range(0, 2)) send_item(OP_LOOKUP, k, SLOT_W'($urandom), res);
                if ($urandom_range(0, 3) == 0)
                    send_item(OP_ADD, k, res.slot, res);
            end
            else if (pick < 65)
                repeat (($urandom_range(0, 19) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(1, 3))
                    send_item(OP_TICK, $urandom, SLOT_W'($urandom), res);
            else if (pick < 75)
                send_item(OP_LOOKUP, ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom,
                          SLOT_W'($urandom), res);
            else if (pick < 83)
                send_item(OP_ADD, $urandom, SLOT_W'($urandom), res);
            else if (pick < 90)
                send_item(OP_ADD, k, SLOT_W'($urandom), res);
            else if (pick < 95)
                send_item(OP_SPARE, $urandom, SLOT_W'($urandom), res);
            else
            begin
                wait_drained();
                tx_gaps = ($urandom_range(0, 2) != 0);
                rx_gaps = ($urandom_range(0, 2) != 0);
            end
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        wait_drained();
    endtask

    // The receiver holds off while the sender keeps offering back-to-back transactions.
    task automatic test_output_backpressure();
        probe_result_t res;
        int            i;
        tx_gaps = 1'b0;
        rx_hold_req = 1'b1;
        for (i = 0; i < 24; i++)
        begin
            if (i % 4 == 3)
                send_item(OP_TICK, $urandom, SLOT_W'($urandom), res);
            else
                send_item(OP_LOOKUP, key_pool[$urandom_range(0, POOL_SIZE - 1)],
                          SLOT_W'($urandom), res);
        end
        tx_gaps = 1'b1;
        wait_drained();
    endtask

    // Fill every slot within one tick so that nothing is reusable, then probe for
    // an absent key; afterwards let the entries expire and empty one slot.
    task automatic test_table_full();
        probe_result_t res;
        int            i;
        for (i = 0; i < TABLE_SLOTS; i++)
            send_item(OP_ADD, 32'hF000_0000 | i, SLOT_W'(i), res);
        send_item(OP_LOOKUP, ABSENT_KEY, '0, res);
        send_item(OP_LOOKUP, 32'hF000_0011, '0, res);
        send_item(OP_ADD, ABSENT_KEY ^ 32'd1, SLOT_W'(9), res);
        send_item(OP_TICK, '0, '0, res);
        send_item(OP_LOOKUP, ABSENT_KEY, '0, res);
        send_item(OP_ADD, '0, SLOT_W'(3), res);
        send_item(OP_LOOKUP, ABSENT_KEY, '0, res);
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        probe_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing pending, tdata %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, m_axis_tdata[0]);
                    mismatches++;
                end
                if (m_axis_tdata[SLOT_W:1] !== want.slot)
                begin
                    $error("result_slot: expected %0d, actual %0d", want.slot,
                           m_axis_tdata[SLOT_W:1]);
                    mismatches++;
                end
                if (m_axis_tdata[SLOT_W+1] !== want.full)
                begin
                    $error("table_full: expected %0d, actual %0d", want.full,
                           m_axis_tdata[SLOT_W+1]);
                    mismatches++;
                end
                if (m_axis_tdata[SLOT_W+2 +: COUNT_W] !== want.count)
                begin
                    $error("entry_count: expected %0d, actual %0d", want.count,
                           m_axis_tdata[SLOT_W+2 +: COUNT_W]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int stall_left;
        int r;
        m_axis_tready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!rx_gaps)
                m_axis_tready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    m_axis_tready <= 1'b1;
                else
                begin
                    stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(15, 60);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_TICK;
        mismatches = 0;
        items_sent = 0;
        idle_cycles = 0;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        rx_hold_req = 1'b0;
        shadow_now = '0;
        shadow_installs = '0;
        for (i = 0; i < TABLE_SLOTS; i++)
        begin
            tbl_key[i] = '0;
            tbl_born[i] = '0;
            tbl_seen[i] = '0;
            tbl_life[i] = '0;
            tbl_backoff[i] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_cases();
        test_tick_wrap();
        test_random_traffic();
        test_output_backpressure();
        test_table_full();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
